>>> hdl/v2t_pkg.sv
`default_nettype none

package v2t_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef struct packed {
        logic signed [15:0] in_x;
        logic signed [15:0] in_y;
        logic               in_last;
    } vertex_in_t;

    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic               out_last;
        logic               clipped;
    } vertex_out_t;

    typedef enum logic [2:0] {
        REG_MODE         = 3'd0,
        REG_OFFSET_X     = 3'd1,
        REG_OFFSET_Y     = 3'd2,
        REG_ANGLE_DEG    = 3'd3,
        REG_FACTOR_X     = 3'd4,
        REG_FACTOR_Y     = 3'd5,
        REG_REFLECT_KIND = 3'd6,
        REG_SHEAR_KIND   = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        MODE_TRANSLATE = 3'd0,
        MODE_ROTATE    = 3'd1,
        MODE_SCALE     = 3'd2,
        MODE_REFLECT   = 3'd3,
        MODE_SHEAR     = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        REFL_ORIGIN    = 3'd0,
        REFL_X_AXIS    = 3'd1,
        REFL_Y_AXIS    = 3'd2,
        REFL_DIAG      = 3'd3,
        REFL_ANTIDIAG  = 3'd4,
        REFL_NONE      = 3'd5
    } reflect_t;

    typedef enum logic [1:0] {
        SHIFT_NONE = 2'd0,
        SHIFT_Q8   = 2'd1,
        SHIFT_TRIG = 2'd2
    } shift_t;

    localparam int SHEAR_X_BIT = 0;
    localparam int SHEAR_Y_BIT = 1;

    localparam logic [2:0]         MODE_RESET    = 3'd0;
    localparam logic signed [15:0] OFFSET_RESET  = 16'sd0;
    localparam logic [8:0]         ANGLE_RESET   = 9'd0;
    localparam logic signed [15:0] FACTOR_RESET  = 16'sd256;
    localparam logic [2:0]         REFLECT_RESET = 3'd5;
    localparam logic [1:0]         SHEAR_RESET   = 2'd0;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    // Q1.frac sine of d degrees, 0 <= d <= 90, from a Q30 Taylor series
    function automatic logic [16:0] sin_quarter(input int unsigned d, input int unsigned frac);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        mag;
        logic signed [63:0] sum;
        logic signed [63:0] r;
        logic signed [63:0] one;
        begin
            x   = (64'(d) * PI_Q30) / 64'd180;
            x2  = (x * x) >> 30;
            mag = x;
            sum = $signed(x);
            mag = ((mag * x2) >> 30) / 64'd6;
            sum = sum - $signed(mag);
            mag = ((mag * x2) >> 30) / 64'd20;
            sum = sum + $signed(mag);
            mag = ((mag * x2) >> 30) / 64'd42;
            sum = sum - $signed(mag);
            mag = ((mag * x2) >> 30) / 64'd72;
            sum = sum + $signed(mag);
            mag = ((mag * x2) >> 30) / 64'd110;
            sum = sum - $signed(mag);
            mag = ((mag * x2) >> 30) / 64'd156;
            sum = sum + $signed(mag);
            mag = ((mag * x2) >> 30) / 64'd210;
            sum = sum - $signed(mag);
            mag = ((mag * x2) >> 30) / 64'd272;
            sum = sum + $signed(mag);
            if (sum < 0)
            begin
                sum = 64'sd0;
            end
            r   = (sum + (64'sd1 <<< (29 - frac))) >>> (30 - frac);
            one = 64'sd1 <<< frac;
            if (r > one)
            begin
                r = one;
            end
            return r[16:0];
        end
    endfunction

endpackage

`default_nettype wire

>>> hdl/v2t_lane.sv
`default_nettype none

module v2t_lane #(
    parameter int AW   = 17,
    parameter int BW   = 16,
    parameter int SW   = 35,
    parameter int FRAC = 14
) (
    input  logic                  clk,
    input  logic signed [AW-1:0]  a1,
    input  logic signed [BW-1:0]  b1,
    input  logic signed [AW-1:0]  a2,
    input  logic signed [BW-1:0]  b2,
    input  logic signed [SW-1:0]  k,
    input  v2t_pkg::shift_t       shift,
    output logic signed [15:0]    value,
    output logic                  clip
);
    import v2t_pkg::*;

    localparam int PW = AW + BW;
    localparam logic signed [SW-1:0] BIAS_Q8   = SW'(255);
    localparam logic signed [SW-1:0] BIAS_TRIG = SW'((1 << FRAC) - 1);
    localparam logic signed [SW-1:0] MAX_V     = SW'(32767);
    localparam logic signed [SW-1:0] MIN_V     = -SW'(32768);

    logic signed [PW-1:0] p1_reg;
    logic signed [PW-1:0] p2_reg;
    logic signed [SW-1:0] k_reg;
    shift_t               shift_s3_reg;
    logic signed [SW-1:0] sum_reg;
    shift_t               shift_s4_reg;
    logic signed [SW-1:0] biased;
    logic signed [SW-1:0] shifted;
    logic signed [15:0]   value_reg;
    logic signed [15:0]   value_next;
    logic                 clip_reg;
    logic                 clip_next;

    always_ff @(posedge clk)
    begin
        p1_reg       <= a1 * b1;
        p2_reg       <= a2 * b2;
        k_reg        <= k;
        shift_s3_reg <= shift;
        sum_reg      <= SW'(p1_reg) + SW'(p2_reg) + k_reg;
        shift_s4_reg <= shift_s3_reg;
        value_reg    <= value_next;
        clip_reg     <= clip_next;
    end

    // round toward zero: bias negative values before the arithmetic shift
    always_comb
    begin
        biased  = sum_reg;
        shifted = sum_reg;
        case (shift_s4_reg)
            SHIFT_NONE:
            begin
                shifted = sum_reg;
            end
            SHIFT_Q8:
            begin
                biased  = sum_reg + (sum_reg[SW-1] ? BIAS_Q8 : '0);
                shifted = biased >>> 8;
            end
            SHIFT_TRIG:
            begin
                biased  = sum_reg + (sum_reg[SW-1] ? BIAS_TRIG : '0);
                shifted = biased >>> FRAC;
            end
            default:
            begin
                shifted = sum_reg;
            end
        endcase

        if (shifted > MAX_V)
        begin
            value_next = 16'sh7fff;
            clip_next  = 1'b1;
        end
        else if (shifted < MIN_V)
        begin
            value_next = 16'sh8000;
            clip_next  = 1'b1;
        end
        else
        begin
            value_next = shifted[15:0];
            clip_next  = 1'b0;
        end
    end

    assign value = value_reg;
    assign clip  = clip_reg;

endmodule

`default_nettype wire

>>> hdl/vertex_2d_transform_core.sv
`default_nettype none

// 2D affine vertex transform.
// Configuration: write cfg_data into register cfg_index while cfg_we is high;
// registers are mode, offset x/y, angle, factor x/y, reflect kind, shear kind.
// Write them only while no vertex is in flight.
// Input: a vertex transaction is taken at each clock edge with start high and
// busy low. busy stays low, so one vertex can be taken every cycle.
// Output: each result shows on result for exactly one cycle with done high;
// results come in input order. The receiver cannot stall.
// Pipeline: operand select with sine/cosine lookup, two multipliers per axis,
// sum, then round toward zero and saturate; one vertex per cycle sustained.
// TRIG_FRAC_BITS sets the Q1.F precision of the sine/cosine table.
// Reset clears the pipeline valid bits and loads the default configuration:
// translate, zero offsets and angle, unit factors, no reflection, no shear.

module vertex_2d_transform_core #(
    parameter int TRIG_FRAC_BITS = 14
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  v2t_pkg::vertex_in_t                 item,
    output logic                                done,
    output v2t_pkg::vertex_out_t                result,
    input  logic                                cfg_we,
    input  logic [v2t_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [v2t_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import v2t_pkg::*;

    localparam int F  = TRIG_FRAC_BITS;
    localparam int AW = 17;
    localparam int BW = (F + 2 > 16) ? F + 2 : 16;
    localparam int SW = AW + BW + 2;

    localparam logic signed [BW-1:0] B_ONE     = BW'(1);
    localparam logic signed [BW-1:0] B_NEG_ONE = -BW'(1);
    localparam logic signed [BW-1:0] B_Q8_ONE  = BW'(256);

    typedef struct packed {
        logic [6:0] idx;
        logic       neg;
    } fold_t;

    logic [2:0]         mode_reg;
    logic signed [15:0] offset_x_reg;
    logic signed [15:0] offset_y_reg;
    logic [8:0]         angle_reg;
    logic signed [15:0] factor_x_reg;
    logic signed [15:0] factor_y_reg;
    logic [2:0]         reflect_reg;
    logic [1:0]         shear_reg;

    logic               s1_valid_reg;
    vertex_in_t         s1_item_reg;
    logic               s2_valid_reg;
    logic               s2_last_reg;
    logic               s3_valid_reg;
    logic               s3_last_reg;
    logic               s4_valid_reg;
    logic               s4_last_reg;
    logic               done_reg;
    logic               out_last_reg;

    logic signed [AW-1:0] s2_ax1_reg, s2_ax2_reg, s2_ay1_reg, s2_ay2_reg;
    logic signed [BW-1:0] s2_bx1_reg, s2_bx2_reg, s2_by1_reg, s2_by2_reg;
    logic signed [SW-1:0] s2_kx_reg, s2_ky_reg;
    shift_t               s2_shx_reg, s2_shy_reg;

    logic signed [AW-1:0] ax1_next, ax2_next, ay1_next, ay2_next;
    logic signed [BW-1:0] bx1_next, bx2_next, by1_next, by2_next;
    logic signed [SW-1:0] kx_next, ky_next;
    shift_t               shx_next, shy_next;

    logic [F:0]           sin_tab [0:90];
    logic [8:0]           ang;
    logic [9:0]           ang90;
    logic [8:0]           ang_c;
    fold_t                fold_s;
    fold_t                fold_c;
    logic signed [F+1:0]  sin_val;
    logic signed [F+1:0]  cos_val;
    logic signed [AW-1:0] x17, y17, dx, dy;

    logic signed [15:0]   val_x, val_y;
    logic                 clip_x, clip_y;

    for (genvar g = 0; g <= 90; g++)
    begin : g_sin
        localparam logic [16:0] V = sin_quarter(g, F);
        assign sin_tab[g] = V[F:0];
    end

    function automatic fold_t fold(input logic [8:0] d);
        fold_t f;
        begin
            if (d <= 9'd90)
            begin
                f.idx = d[6:0];
                f.neg = 1'b0;
            end
            else if (d <= 9'd180)
            begin
                f.idx = 7'(9'd180 - d);
                f.neg = 1'b0;
            end
            else if (d <= 9'd270)
            begin
                f.idx = 7'(d - 9'd180);
                f.neg = 1'b1;
            end
            else
            begin
                f.idx = 7'(9'd360 - d);
                f.neg = 1'b1;
            end
            return f;
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_RESET;
            offset_x_reg <= OFFSET_RESET;
            offset_y_reg <= OFFSET_RESET;
            angle_reg    <= ANGLE_RESET;
            factor_x_reg <= FACTOR_RESET;
            factor_y_reg <= FACTOR_RESET;
            reflect_reg  <= REFLECT_RESET;
            shear_reg    <= SHEAR_RESET;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_MODE:         mode_reg     <= cfg_data[2:0];
                REG_OFFSET_X:     offset_x_reg <= cfg_data;
                REG_OFFSET_Y:     offset_y_reg <= cfg_data;
                REG_ANGLE_DEG:    angle_reg    <= cfg_data[8:0];
                REG_FACTOR_X:     factor_x_reg <= cfg_data;
                REG_FACTOR_Y:     factor_y_reg <= cfg_data;
                REG_REFLECT_KIND: reflect_reg  <= cfg_data[2:0];
                REG_SHEAR_KIND:   shear_reg    <= cfg_data[1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            done_reg     <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg  <= item;
        s2_last_reg  <= s1_item_reg.in_last;
        s3_last_reg  <= s2_last_reg;
        s4_last_reg  <= s3_last_reg;
        out_last_reg <= s4_last_reg;
        s2_ax1_reg   <= ax1_next;
        s2_ax2_reg   <= ax2_next;
        s2_ay1_reg   <= ay1_next;
        s2_ay2_reg   <= ay2_next;
        s2_bx1_reg   <= bx1_next;
        s2_bx2_reg   <= bx2_next;
        s2_by1_reg   <= by1_next;
        s2_by2_reg   <= by2_next;
        s2_kx_reg    <= kx_next;
        s2_ky_reg    <= ky_next;
        s2_shx_reg   <= shx_next;
        s2_shy_reg   <= shy_next;
    end

    always_comb
    begin
        ang     = (angle_reg >= 9'd360) ? angle_reg - 9'd360 : angle_reg;
        ang90   = {1'b0, ang} + 10'd90;
        ang_c   = (ang90 >= 10'd360) ? 9'(ang90 - 10'd360) : ang90[8:0];
        fold_s  = fold(ang);
        fold_c  = fold(ang_c);
        sin_val = fold_s.neg ? -$signed({1'b0, sin_tab[fold_s.idx]})
                             : $signed({1'b0, sin_tab[fold_s.idx]});
        cos_val = fold_c.neg ? -$signed({1'b0, sin_tab[fold_c.idx]})
                             : $signed({1'b0, sin_tab[fold_c.idx]});
        x17     = AW'(s1_item_reg.in_x);
        y17     = AW'(s1_item_reg.in_y);
        dx      = x17 - AW'(offset_x_reg);
        dy      = y17 - AW'(offset_y_reg);

        ax1_next = x17;
        bx1_next = B_ONE;
        ax2_next = '0;
        bx2_next = '0;
        kx_next  = '0;
        shx_next = SHIFT_NONE;
        ay1_next = y17;
        by1_next = B_ONE;
        ay2_next = '0;
        by2_next = '0;
        ky_next  = '0;
        shy_next = SHIFT_NONE;

        case (mode_reg)
            MODE_TRANSLATE:
            begin
                kx_next = SW'(offset_x_reg);
                ky_next = SW'(offset_y_reg);
            end
            MODE_ROTATE:
            begin
                ax1_next = dx;
                bx1_next = BW'(cos_val);
                ax2_next = dy;
                bx2_next = -BW'(sin_val);
                kx_next  = SW'(offset_x_reg) <<< F;
                shx_next = SHIFT_TRIG;
                ay1_next = dx;
                by1_next = BW'(sin_val);
                ay2_next = dy;
                by2_next = BW'(cos_val);
                ky_next  = SW'(offset_y_reg) <<< F;
                shy_next = SHIFT_TRIG;
            end
            MODE_SCALE:
            begin
                bx1_next = BW'(factor_x_reg);
                shx_next = SHIFT_Q8;
                by1_next = BW'(factor_y_reg);
                shy_next = SHIFT_Q8;
            end
            MODE_REFLECT:
            begin
                case (reflect_reg)
                    REFL_ORIGIN:
                    begin
                        bx1_next = B_NEG_ONE;
                        by1_next = B_NEG_ONE;
                    end
                    REFL_X_AXIS:
                    begin
                        by1_next = B_NEG_ONE;
                    end
                    REFL_Y_AXIS:
                    begin
                        bx1_next = B_NEG_ONE;
                    end
                    REFL_DIAG:
                    begin
                        ax1_next = y17;
                        ay1_next = x17;
                    end
                    REFL_ANTIDIAG:
                    begin
                        ax1_next = y17;
                        bx1_next = B_NEG_ONE;
                        ay1_next = x17;
                        by1_next = B_NEG_ONE;
                    end
                    default:
                    begin
                        bx1_next = B_ONE;
                    end
                endcase
            end
            MODE_SHEAR:
            begin
                if (shear_reg[SHEAR_X_BIT])
                begin
                    bx1_next = B_Q8_ONE;
                    ax2_next = y17;
                    bx2_next = BW'(factor_x_reg);
                    shx_next = SHIFT_Q8;
                end
                if (shear_reg[SHEAR_Y_BIT])
                begin
                    by1_next = B_Q8_ONE;
                    ay2_next = x17;
                    by2_next = BW'(factor_y_reg);
                    shy_next = SHIFT_Q8;
                end
            end
            default:
            begin
                kx_next = '0;
            end
        endcase
    end

    v2t_lane #(
        .AW   (AW),
        .BW   (BW),
        .SW   (SW),
        .FRAC (F)
    ) u_lane_x (
        .clk   (clk),
        .a1    (s2_ax1_reg),
        .b1    (s2_bx1_reg),
        .a2    (s2_ax2_reg),
        .b2    (s2_bx2_reg),
        .k     (s2_kx_reg),
        .shift (s2_shx_reg),
        .value (val_x),
        .clip  (clip_x)
    );

    v2t_lane #(
        .AW   (AW),
        .BW   (BW),
        .SW   (SW),
        .FRAC (F)
    ) u_lane_y (
        .clk   (clk),
        .a1    (s2_ay1_reg),
        .b1    (s2_by1_reg),
        .a2    (s2_ay2_reg),
        .b2    (s2_by2_reg),
        .k     (s2_ky_reg),
        .shift (s2_shy_reg),
        .value (val_y),
        .clip  (clip_y)
    );

    assign busy = 1'b0;
    assign done = done_reg;

    always_comb
    begin
        result.out_x    = val_x;
        result.out_y    = val_y;
        result.out_last = out_last_reg;
        result.clipped  = clip_x | clip_y;
    end

endmodule

`default_nettype wire

>>> bench/vertex_transform_checker.sv
module vertex_transform_checker #(
    parameter int FRAC_BITS = 14
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  v2t_pkg::vertex_in_t               item,
    input  logic                              done,
    input  v2t_pkg::vertex_out_t              result,
    input  logic                              cfg_we,
    input  logic [v2t_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [v2t_pkg::CFG_DATA_W-1:0]    cfg_data,
    output int                                fail_count,
    output int                                pending,
    output int                                checked,
    output int                                saturated
);
    timeunit 1ns;
    timeprecision 1ps;

    import v2t_pkg::*;

    localparam logic [63:0] HALF_TURN_Q30 = 64'd3373259426;
    localparam longint      TRIG_ONE      = longint'(1) << FRAC_BITS;
    localparam longint      Q8_ONE        = 256;
    localparam int          FULL_TURN     = 360;
    localparam int          REPORT_LIMIT  = 10;

    logic [2:0]         mode_r;
    logic signed [15:0] ofs_x;
    logic signed [15:0] ofs_y;
    logic [8:0]         angle_r;
    logic signed [15:0] gain_x;
    logic signed [15:0] gain_y;
    logic [2:0]         mirror_r;
    logic [1:0]         shear_r;

    longint             sine_q [0:90];
    vertex_out_t        expected_vertices [$];
    vertex_out_t        oldest;

    function automatic longint quarter_sine(input int unsigned deg);
        logic [63:0] ang;
        logic [63:0] ang_sq;
        logic [63:0] term;
        longint      acc;
        longint      rounded;
        ang    = 64'(deg) * HALF_TURN_Q30 / 64'd180;
        ang_sq = (ang * ang) >> 30;
        term   = ang;
        acc    = longint'(ang);
        for (int n = 1; n <= 8; n++)
        begin
            term = ((term * ang_sq) >> 30) / 64'(2 * n * (2 * n + 1));
            if (n % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        rounded = (acc + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        return (rounded > TRIG_ONE) ? TRIG_ONE : rounded;
    endfunction

    initial
    begin
        for (int d = 0; d <= 90; d++)
            sine_q[d] = quarter_sine(d);
    end

    function automatic longint sine_deg(input int unsigned deg);
        if (deg <= 90)
            return sine_q[deg];
        if (deg <= 180)
            return sine_q[180 - deg];
        if (deg <= 270)
            return -sine_q[deg - 180];
        return -sine_q[FULL_TURN - deg];
    endfunction

    function automatic logic out_of_range(input longint v);
        return (v > 32767) || (v < -32768);
    endfunction

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return 16'(v);
    endfunction

    function automatic vertex_out_t transform_vertex(input vertex_in_t v);
        longint      x;
        longint      y;
        longint      ox;
        longint      oy;
        longint      fx;
        longint      fy;
        longint      rx;
        longint      ry;
        longint      dx;
        longint      dy;
        longint      sn;
        longint      cs;
        int unsigned deg;
        vertex_out_t r;
        x  = longint'($signed(v.in_x));
        y  = longint'($signed(v.in_y));
        ox = longint'(ofs_x);
        oy = longint'(ofs_y);
        fx = longint'(gain_x);
        fy = longint'(gain_y);
        rx = x;
        ry = y;
        case (mode_r)
            MODE_TRANSLATE:
            begin
                rx = x + ox;
                ry = y + oy;
            end
            MODE_ROTATE:
            begin
                deg = {23'b0, angle_r};
                if (deg >= FULL_TURN)
                    deg = deg - FULL_TURN;
                sn = sine_deg(deg);
                cs = sine_deg((deg + 90) % FULL_TURN);
                dx = x - ox;
                dy = y - oy;
                rx = (dx * cs - dy * sn + ox * TRIG_ONE) / TRIG_ONE;
                ry = (dx * sn + dy * cs + oy * TRIG_ONE) / TRIG_ONE;
            end
            MODE_SCALE:
            begin
                rx = (x * fx) / Q8_ONE;
                ry = (y * fy) / Q8_ONE;
            end
            MODE_REFLECT:
            begin
                case (mirror_r)
                    REFL_ORIGIN:
                    begin
                        rx = -x;
                        ry = -y;
                    end
                    REFL_X_AXIS:
                        ry = -y;
                    REFL_Y_AXIS:
                        rx = -x;
                    REFL_DIAG:
                    begin
                        rx = y;
                        ry = x;
                    end
                    REFL_ANTIDIAG:
                    begin
                        rx = -y;
                        ry = -x;
                    end
                    default:
                        ;
                endcase
            end
            MODE_SHEAR:
            begin
                if (shear_r[SHEAR_X_BIT])
                    rx = (x * Q8_ONE + y * fx) / Q8_ONE;
                if (shear_r[SHEAR_Y_BIT])
                    ry = (y * Q8_ONE + x * fy) / Q8_ONE;
            end
            default:
                ;
        endcase
        r.out_x    = clamp16(rx);
        r.out_y    = clamp16(ry);
        r.out_last = v.in_last;
        r.clipped  = out_of_range(rx) || out_of_range(ry);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_r     <= MODE_TRANSLATE;
            ofs_x      <= '0;
            ofs_y      <= '0;
            angle_r    <= '0;
            gain_x     <= 16'sd256;
            gain_y     <= 16'sd256;
            mirror_r   <= REFL_NONE;
            shear_r    <= '0;
            expected_vertices.delete();
            fail_count <= 0;
            pending    <= 0;
            checked    <= 0;
            saturated  <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_MODE:         mode_r   <= cfg_data[2:0];
                    REG_OFFSET_X:     ofs_x    <= $signed(cfg_data);
                    REG_OFFSET_Y:     ofs_y    <= $signed(cfg_data);
                    REG_ANGLE_DEG:    angle_r  <= cfg_data[8:0];
                    REG_FACTOR_X:     gain_x   <= $signed(cfg_data);
                    REG_FACTOR_Y:     gain_y   <= $signed(cfg_data);
                    REG_REFLECT_KIND: mirror_r <= cfg_data[2:0];
                    REG_SHEAR_KIND:   shear_r  <= cfg_data[1:0];
                    default:          ;
                endcase
            end
            if (start && !busy)
                expected_vertices.push_back(transform_vertex(item));
            if (done)
            begin
                checked <= checked + 1;
                if (result.clipped)
                    saturated <= saturated + 1;
                if (expected_vertices.size() == 0)
                begin
                    if (fail_count < REPORT_LIMIT)
                        $display("%0t: unexpected result x=%0d y=%0d last=%0b clip=%0b",
                                 $time, $signed(result.out_x), $signed(result.out_y),
                                 result.out_last, result.clipped);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    oldest = expected_vertices.pop_front();
                    if (result.out_x !== oldest.out_x || result.out_y !== oldest.out_y ||
                        result.out_last !== oldest.out_last ||
                        result.clipped !== oldest.clipped)
                    begin
                        if (fail_count < REPORT_LIMIT)
                        begin
                            $write("%0t: mismatch, expected x=%0d y=%0d last=%0b clip=%0b,",
                                   $time, $signed(oldest.out_x), $signed(oldest.out_y),
                                   oldest.out_last, oldest.clipped);
                            $display(" got x=%0d y=%0d last=%0b clip=%0b",
                                     $signed(result.out_x), $signed(result.out_y),
                                     result.out_last, result.clipped);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= expected_vertices.size();
        end
    end

endmodule

>>> bench/tb_vertex_2d_transform_core.sv
module tb_vertex_2d_transform_core;
    timeunit 1ns;
    timeprecision 1ps;

    import v2t_pkg::*;

    localparam int FRAC_BITS      = 14;
    localparam int PIPE_LATENCY   = 5;
    localparam int TOTAL_ITEMS    = 1550;
    localparam int WATCHDOG_LIMIT = 5000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    vertex_in_t            item      = '0;
    logic                  done;
    vertex_out_t           result;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int                    fail_count;
    int                    pending;
    int                    checked;
    int                    saturated;

    logic [15:0]           regs [8];
    int                    idle_pct_by_phase [4] = '{0, 88, 37, 0};
    int                    vertices_sent   = 0;
    int                    configs_applied = 0;
    int                    stall_cycles    = 0;
    int                    phase;
    int                    batch;
    int                    pause_at;

    vertex_2d_transform_core #(
        .TRIG_FRAC_BITS(FRAC_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    vertex_transform_checker #(
        .FRAC_BITS(FRAC_BITS)
    ) xform_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .item       (item),
        .done       (done),
        .result     (result),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked),
        .saturated  (saturated)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transaction for %0d cycles", stall_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_vertex(input logic signed [15:0] x, input logic signed [15:0] y,
                               input logic last, input int idle_pct);
        while ($urandom_range(99, 0) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        // hold start until the transaction is taken
        start <= 1'b1;
        item  <= '{in_x: x, in_y: y, in_last: last};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        vertices_sent++;
    endtask

    // drop start and wait for every outstanding result
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic apply_config();
        drain();
        repeat (PIPE_LATENCY) @(posedge clk);
        for (int i = 0; i < 8; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= regs[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        configs_applied++;
    endtask

    function automatic logic signed [15:0] random_coord();
        case ($urandom_range(9, 0))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'(int'($urandom_range(2, 0)) - 1);
            3, 4, 5: return 16'(int'($urandom_range(2047, 0)) - 1024);
            default: return 16'($urandom);
        endcase
    endfunction

    // set bits above the register width now and then
    function automatic logic [15:0] with_junk(input logic [15:0] value, input int width);
        logic [15:0] spare;
        spare = 16'($urandom) << width;
        return ($urandom_range(3, 0) == 0) ? (value | spare) : value;
    endfunction

    function automatic void choose_config(input int phase_no);
        int ang;
        if (phase_no % 10 == 9)
            regs[REG_MODE] = with_junk(16'($urandom_range(7, MODE_SHEAR + 1)), 3);
        else
            regs[REG_MODE] = with_junk(16'(phase_no % 5), 3);
        for (int i = REG_OFFSET_X; i <= REG_OFFSET_Y; i++)
        begin
            case ($urandom_range(5, 0))
                0:       regs[i] = 16'h8000;
                1:       regs[i] = 16'h7FFF;
                2:       regs[i] = '0;
                3, 4:    regs[i] = 16'(int'($urandom_range(4095, 0)) - 2048);
                default: regs[i] = 16'($urandom);
            endcase
        end
        for (int i = REG_FACTOR_X; i <= REG_FACTOR_Y; i++)
        begin
            case ($urandom_range(6, 0))
                0:       regs[i] = 16'h8000;
                1:       regs[i] = 16'h7FFF;
                2:       regs[i] = 16'h0100;
                3:       regs[i] = 16'hFF00;
                4, 5:    regs[i] = 16'(int'($urandom_range(1023, 0)) - 512);
                default: regs[i] = 16'($urandom);
            endcase
        end
        case ($urandom_range(5, 0))
            0:       ang = 0;
            1:       ang = 359;
            2:       ang = 90 * $urandom_range(3, 1);
            3:       ang = $urandom_range(511, 360);
            default: ang = $urandom_range(359, 0);
        endcase
        regs[REG_ANGLE_DEG]    = with_junk(16'(ang), 9);
        regs[REG_REFLECT_KIND] = with_junk(16'($urandom_range(7, 0)), 3);
        regs[REG_SHEAR_KIND]   = with_junk(16'($urandom_range(3, 0)), 2);
    endfunction

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        regs[REG_MODE]         = 16'(MODE_TRANSLATE);
        regs[REG_OFFSET_X]     = '0;
        regs[REG_OFFSET_Y]     = '0;
        regs[REG_ANGLE_DEG]    = '0;
        regs[REG_FACTOR_X]     = 16'h0100;
        regs[REG_FACTOR_Y]     = 16'h0100;
        regs[REG_REFLECT_KIND] = 16'(REFL_NONE);
        regs[REG_SHEAR_KIND]   = '0;
        apply_config();
        send_vertex(16'sh7FFF, 16'sh7FFF, 1'b1, 0);
        send_vertex(16'sh8000, 16'sh8000, 1'b0, 0);

        regs[REG_OFFSET_X] = 16'h7FFF;
        regs[REG_OFFSET_Y] = 16'h8000;
        apply_config();
        send_vertex(16'sd1, -16'sd1, 1'b0, 0);
        send_vertex(16'sh8000, 16'sh7FFF, 1'b1, 0);

        regs[REG_MODE]      = 16'(MODE_ROTATE);
        regs[REG_OFFSET_X]  = '0;
        regs[REG_OFFSET_Y]  = '0;
        regs[REG_ANGLE_DEG] = 16'd90;
        apply_config();
        send_vertex(16'sd1000, -16'sd2000, 1'b0, 0);
        regs[REG_ANGLE_DEG] = 16'd450;
        apply_config();
        send_vertex(16'sh8000, 16'sh7FFF, 1'b1, 0);
        regs[REG_OFFSET_X]  = 16'd100;
        regs[REG_OFFSET_Y]  = -16'sd50;
        regs[REG_ANGLE_DEG] = 16'd180;
        apply_config();
        send_vertex(16'sh8000, 16'sh8000, 1'b0, 0);
        regs[REG_ANGLE_DEG] = 16'd359;
        apply_config();
        send_vertex(16'sd12345, -16'sd54, 1'b1, 0);

        regs[REG_MODE]     = 16'(MODE_SCALE);
        regs[REG_FACTOR_X] = 16'h8000;
        regs[REG_FACTOR_Y] = 16'h7FFF;
        apply_config();
        send_vertex(16'sh7FFF, 16'sh8000, 1'b0, 0);
        send_vertex(-16'sd1, 16'sd1, 1'b1, 0);

        regs[REG_MODE] = 16'(MODE_REFLECT);
        for (int k = REFL_ORIGIN; k < 8; k++)
        begin
            regs[REG_REFLECT_KIND] = 16'(k);
            apply_config();
            send_vertex(16'sh8000, 16'sd77, 1'(k), 0);
        end

        regs[REG_MODE]     = 16'(MODE_SHEAR);
        regs[REG_FACTOR_X] = 16'h0080;
        regs[REG_FACTOR_Y] = 16'hFF00;
        for (int k = 1 << SHEAR_X_BIT; k <= ((1 << SHEAR_X_BIT) | (1 << SHEAR_Y_BIT)); k++)
        begin
            regs[REG_SHEAR_KIND] = 16'(k);
            apply_config();
            send_vertex(16'sh8000, 16'sh7FFF, 1'b0, 0);
        end

        for (int m = MODE_SHEAR + 1; m < 8; m++)
        begin
            regs[REG_MODE] = 16'hFFF8 | 16'(m);
            apply_config();
            send_vertex(-16'sd7, 16'sd9, 1'b1, 0);
        end

        phase = 0;
        while (vertices_sent < TOTAL_ITEMS)
        begin
            choose_config(phase);
            apply_config();
            batch    = $urandom_range(90, 40);
            pause_at = (phase % 3 == 1) ? batch / 2 : -1;
            for (int n = 0; n < batch; n++)
            begin
                if (n == pause_at)
                    drain();
                send_vertex(random_coord(), random_coord(), $urandom_range(5, 0) == 0,
                            idle_pct_by_phase[phase % 4]);
            end
            phase++;
        end

        drain();
        repeat (PIPE_LATENCY + 3) @(posedge clk);

        $display("Covered %0d vertices under %0d register settings: all mode codes,",
                 vertices_sent, configs_applied);
        $display("  every mirror and shear kind, wrapped angles, %0d of %0d results saturated.",
                 saturated, checked);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
